### rtl/wfvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfvf_pkg: shared types and constants of the frequent value filter
// Command codes, register indexes, reset values and the control and status
// bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package wfvf_pkg;

    localparam int HISTORY_DEPTH_DEF   = 64;
    localparam int TRACKED_ENTRIES_DEF = 256;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] REG_PROMOTE = 2'd0;
    localparam logic [1:0] REG_WINDOW  = 2'd1;
    localparam logic [1:0] REG_REPORT  = 2'd2;

    localparam logic [31:0] PROMOTE_RST = 32'd2;
    localparam logic [6:0]  WINDOW_RST  = 7'd64;
    localparam logic [31:0] REPORT_RST  = 32'd1;

    typedef struct packed {
        logic accept;
        logic head_rd;
        logic scan_clr;
        logic tscan;
        logic cscan;
        logic apply;
        logic evict;
        logic rd_issue;
        logic rd_cap;
        logic out_load;
    } wfvf_cmd_t;

    typedef struct packed {
        logic [1:0] in_cmd;
        logic       scan_done;
        logic       t_hit;
        logic       evict_need;
        logic       out_free;
    } wfvf_sts_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

### rtl/wfvf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfvf_ctrl: sequencer of the frequent value filter
// Steps a sample through head read, table scans, update and result, and a read through a table read.
// ----------------------------------------------------------------------------
module wfvf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wfvf_pkg::wfvf_sts_t sts,
    output wfvf_pkg::wfvf_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HEAD  = 9'b000000010,
        S_TSCAN = 9'b000000100,
        S_CSCAN = 9'b000001000,
        S_APPLY = 9'b000010000,
        S_EVICT = 9'b000100000,
        S_READ  = 9'b001000000,
        S_RDAT  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_cmd == wfvf_pkg::CMD_SAMPLE)
                        state_next = S_HEAD;
                    else if (sts.in_cmd == wfvf_pkg::CMD_READ)
                        state_next = S_READ;
                    else
                        state_next = S_OUT;
                end
            end
            S_HEAD:
            begin
                cmd.head_rd  = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = S_TSCAN;
            end
            S_TSCAN:
            begin
                cmd.tscan = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.t_hit)
                        state_next = S_APPLY;
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_CSCAN;
                    end
                end
            end
            S_CSCAN:
            begin
                cmd.cscan = 1'b1;
                if (sts.scan_done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (!sts.t_hit && sts.evict_need)
                    state_next = S_EVICT;
                else
                    state_next = S_OUT;
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = S_OUT;
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RDAT;
            end
            S_RDAT:
            begin
                cmd.rd_cap = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/wfvf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfvf_dp: datapath of the frequent value filter
// History FIFO, candidate and tracked tables, scan unit, totals and result.
// ----------------------------------------------------------------------------
module wfvf_dp #(
    parameter int HISTORY_DEPTH   = wfvf_pkg::HISTORY_DEPTH_DEF,
    parameter int TRACKED_ENTRIES = wfvf_pkg::TRACKED_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [1:0]          command,
    input  logic signed [63:0]  sample_value,
    input  logic [15:0]         sample_weight,
    input  logic [7:0]          read_index,
    input  wfvf_pkg::wfvf_cmd_t cmd,
    output wfvf_pkg::wfvf_sts_t sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                was_tracked,
    output logic                promoted,
    output logic                table_full,
    output logic [31:0]         sample_total,
    output logic [31:0]         overflow_total,
    output logic signed [63:0]  entry_value,
    output logic [31:0]         entry_count,
    output logic                entry_valid,
    output logic                entry_reported
);

    localparam int CW   = $clog2(HISTORY_DEPTH);
    localparam int HW   = $clog2(HISTORY_DEPTH + 1);
    localparam int TW   = (TRACKED_ENTRIES > 1) ? $clog2(TRACKED_ENTRIES) : 1;
    localparam int SMAX = (TRACKED_ENTRIES > HISTORY_DEPTH) ? TRACKED_ENTRIES : HISTORY_DEPTH;
    localparam int SW   = $clog2(SMAX + 1);

    // configuration
    logic [31:0] pth_reg, rth_reg;
    logic [6:0]  wlen_reg;

    // latched item
    logic [1:0]  op_reg;
    logic [63:0] val_reg;
    logic [15:0] wt_reg;
    logic [7:0]  ridx_reg;

    // storage
    logic [63:0]   hist_mem [HISTORY_DEPTH];
    logic [63:0]   hist_q;
    logic [CW-1:0] head_reg;
    logic [HW-1:0] fill_reg;

    logic [63:0]   cval_mem [HISTORY_DEPTH];
    logic [31:0]   cwt_mem  [HISTORY_DEPTH];
    logic [HW-1:0] cref_mem [HISTORY_DEPTH];
    logic [63:0]   cval_q;
    logic [31:0]   cwt_q;
    logic [HW-1:0] cref_q;
    logic [HISTORY_DEPTH-1:0] cand_live_reg, cand_wclr_reg;

    logic [63:0]   tval_mem [TRACKED_ENTRIES];
    logic [31:0]   tcnt_mem [TRACKED_ENTRIES];
    logic [63:0]   tval_q;
    logic [31:0]   tcnt_q;
    logic [TRACKED_ENTRIES-1:0] trk_live_reg;

    logic [31:0] samples_reg, aged_reg;

    // scan unit
    logic [SW-1:0] cnt_reg, pidx_reg, lim;
    logic          pend_reg, scan_done;

    // search results
    logic          t_hit_reg, t_free_reg, old_t_reg;
    logic [TW-1:0] t_idx_reg, t_free_idx_reg;
    logic [31:0]   t_cnt_reg;
    logic          c_hit_reg, c_free_reg, oc_hit_reg;
    logic [CW-1:0] c_idx_reg, c_free_idx_reg, oc_idx_reg;
    logic [31:0]   c_wt_reg, oc_wt_reg;
    logic [HW-1:0] c_refs_reg, oc_refs_reg;

    logic          prom_reg, full_reg;
    logic          ent_valid_reg, ent_rep_reg;
    logic [63:0]   ent_val_reg;
    logic [31:0]   ent_cnt_reg;

    logic out_valid_reg;

    // ---------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pth_reg  <= wfvf_pkg::PROMOTE_RST;
            wlen_reg <= wfvf_pkg::WINDOW_RST;
            rth_reg  <= wfvf_pkg::REPORT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wfvf_pkg::REG_PROMOTE: pth_reg  <= cfg_data;
                wfvf_pkg::REG_WINDOW:  wlen_reg <= cfg_data[6:0];
                wfvf_pkg::REG_REPORT:  rth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= command;
            val_reg  <= sample_value;
            wt_reg   <= sample_weight;
            ridx_reg <= read_index;
        end
    end

    // ---------------- combinational helpers
    logic [HW-1:0] weff;
    logic [HW:0]   tsum, fill_inc;
    logic [CW-1:0] tail, head_inc;
    logic          evict_need;
    logic [63:0]   old_val;
    logic          same_old;

    always_comb
    begin
        if (wlen_reg == '0)
            weff = HW'(1);
        else if (32'(wlen_reg) > 32'(HISTORY_DEPTH))
            weff = HW'(HISTORY_DEPTH);
        else
            weff = HW'(wlen_reg);
    end

    assign tsum       = (HW+1)'(head_reg) + (HW+1)'(fill_reg);
    assign tail       = (tsum >= (HW+1)'(HISTORY_DEPTH)) ?
                        CW'(tsum - (HW+1)'(HISTORY_DEPTH)) : CW'(tsum);
    assign head_inc   = (32'(head_reg) == HISTORY_DEPTH - 1) ? '0 : head_reg + CW'(1);
    assign fill_inc   = (HW+1)'(fill_reg) + (HW+1)'(1);
    assign evict_need = fill_inc >= (HW+1)'(weff);
    assign old_val    = (fill_reg == '0) ? val_reg : hist_q;
    assign same_old   = (old_val == val_reg);

    // ---------------- scan unit
    assign lim       = cmd.tscan ? SW'(TRACKED_ENTRIES) : SW'(HISTORY_DEPTH);
    assign scan_done = (cnt_reg == lim) && !pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            pidx_reg <= '0;
        end
        else if (cmd.scan_clr)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.tscan || cmd.cscan)
        begin
            if (cnt_reg < lim)
            begin
                cnt_reg  <= cnt_reg + SW'(1);
                pend_reg <= 1'b1;
                pidx_reg <= cnt_reg;
            end
            else
                pend_reg <= 1'b0;
        end
    end

    logic [TW-1:0] pt, ridx_t, tr_addr;
    logic [CW-1:0] pc;
    logic          t_live_p, c_live_p;
    logic [31:0]   c_wt_p;

    assign pt       = pidx_reg[TW-1:0];
    assign pc       = pidx_reg[CW-1:0];
    assign ridx_t   = TW'(ridx_reg);
    assign tr_addr  = cmd.rd_issue ? ridx_t : cnt_reg[TW-1:0];
    assign t_live_p = trk_live_reg[pt];
    assign c_live_p = cand_live_reg[pc];
    assign c_wt_p   = cand_wclr_reg[pc] ? 32'd0 : cwt_q;

    // ---------------- update values
    logic [31:0]   vr_sum, vr_wt;
    logic [HW-1:0] vr_refs, vr_refs_w, oc_refs_dec;
    logic [CW-1:0] vr_idx;
    logic          vr_ok, prom_try, do_prom, drop_now, oc_drop, oc_upd;

    assign vr_sum      = wfvf_pkg::sat_add32(c_wt_reg, {16'd0, wt_reg});
    assign vr_wt       = c_hit_reg ? vr_sum : {16'd0, wt_reg};
    assign vr_refs     = c_hit_reg ? c_refs_reg + HW'(1) : HW'(1);
    assign vr_idx      = c_hit_reg ? c_idx_reg : c_free_idx_reg;
    assign vr_ok       = c_hit_reg || c_free_reg;
    assign prom_try    = c_hit_reg && (vr_sum >= pth_reg);
    assign do_prom     = prom_try && t_free_reg;
    assign vr_refs_w   = (evict_need && same_old) ? vr_refs - HW'(1) : vr_refs;
    assign drop_now    = evict_need && same_old && vr_ok && (vr_refs_w == '0);
    assign oc_upd      = !same_old && oc_hit_reg;
    assign oc_refs_dec = (oc_refs_reg == '0) ? '0 : oc_refs_reg - HW'(1);
    assign oc_drop     = oc_refs_dec == '0;

    logic          c_we, t_we, h_we;
    logic [CW-1:0] c_waddr;
    logic [63:0]   c_wval;
    logic [31:0]   c_wwt;
    logic [HW-1:0] c_wref;
    logic [TW-1:0] t_waddr;
    logic [31:0]   t_wcnt;

    assign h_we    = cmd.apply && !t_hit_reg;
    assign c_we    = (cmd.apply && !t_hit_reg && vr_ok) || (cmd.evict && oc_upd);
    assign c_waddr = cmd.evict ? oc_idx_reg : vr_idx;
    assign c_wval  = cmd.evict ? old_val : val_reg;
    assign c_wwt   = cmd.evict ? oc_wt_reg : vr_wt;
    assign c_wref  = cmd.evict ? oc_refs_dec : vr_refs_w;
    assign t_we    = cmd.apply && (t_hit_reg || do_prom);
    assign t_waddr = t_hit_reg ? t_idx_reg : t_free_idx_reg;
    assign t_wcnt  = t_hit_reg ? wfvf_pkg::sat_add32(t_cnt_reg, {16'd0, wt_reg}) : vr_sum;

    // ---------------- memories
    always_ff @(posedge clk)
    begin
        if (h_we)
            hist_mem[tail] <= val_reg;
        if (cmd.head_rd)
            hist_q <= hist_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cval_mem[c_waddr] <= c_wval;
            cwt_mem[c_waddr]  <= c_wwt;
            cref_mem[c_waddr] <= c_wref;
        end
        cval_q <= cval_mem[cnt_reg[CW-1:0]];
        cwt_q  <= cwt_mem[cnt_reg[CW-1:0]];
        cref_q <= cref_mem[cnt_reg[CW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tval_mem[t_waddr] <= val_reg;
            tcnt_mem[t_waddr] <= t_wcnt;
        end
        tval_q <= tval_mem[tr_addr];
        tcnt_q <= tcnt_mem[tr_addr];
    end

    // ---------------- valid bits, pointers and totals
    logic [31:0] aged_next, samples_next;

    always_comb
    begin
        aged_next    = aged_reg;
        samples_next = samples_reg;
        if (cmd.apply)
        begin
            if (samples_reg != 32'hFFFF_FFFF)
                samples_next = samples_reg + 32'd1;
            if (!t_hit_reg && drop_now && !do_prom)
                aged_next = wfvf_pkg::sat_add32(aged_reg, vr_wt);
        end
        if (cmd.evict && oc_upd && oc_drop && !old_t_reg)
            aged_next = wfvf_pkg::sat_add32(aged_reg, oc_wt_reg);
        if (cmd.accept && command == wfvf_pkg::CMD_CLEAR)
        begin
            aged_next    = '0;
            samples_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            cand_live_reg <= '0;
            cand_wclr_reg <= '0;
            trk_live_reg  <= '0;
            samples_reg   <= '0;
            aged_reg      <= '0;
        end
        else
        begin
            samples_reg <= samples_next;
            aged_reg    <= aged_next;
            if (cmd.accept && command == wfvf_pkg::CMD_CLEAR)
            begin
                trk_live_reg  <= '0;
                cand_wclr_reg <= '1;
            end
            if (cmd.apply && !t_hit_reg)
            begin
                if (evict_need)
                    head_reg <= head_inc;
                else
                    fill_reg <= fill_inc[HW-1:0];
                if (vr_ok)
                begin
                    cand_live_reg[vr_idx] <= !drop_now;
                    cand_wclr_reg[vr_idx] <= 1'b0;
                end
                if (do_prom)
                    trk_live_reg[t_free_idx_reg] <= 1'b1;
            end
            if (cmd.evict && oc_upd && oc_drop)
                cand_live_reg[oc_idx_reg] <= 1'b0;
        end
    end

    // ---------------- search capture and per-item flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_hit_reg      <= 1'b0;
            t_free_reg     <= 1'b0;
            old_t_reg      <= 1'b0;
            c_hit_reg      <= 1'b0;
            c_free_reg     <= 1'b0;
            oc_hit_reg     <= 1'b0;
            prom_reg       <= 1'b0;
            full_reg       <= 1'b0;
            ent_valid_reg  <= 1'b0;
            ent_rep_reg    <= 1'b0;
            ent_val_reg    <= '0;
            ent_cnt_reg    <= '0;
            t_idx_reg      <= '0;
            t_cnt_reg      <= '0;
            t_free_idx_reg <= '0;
            c_idx_reg      <= '0;
            c_wt_reg       <= '0;
            c_refs_reg     <= '0;
            oc_idx_reg     <= '0;
            oc_wt_reg      <= '0;
            oc_refs_reg    <= '0;
            c_free_idx_reg <= '0;
        end
        else if (cmd.accept)
        begin
            t_hit_reg     <= 1'b0;
            t_free_reg    <= 1'b0;
            old_t_reg     <= 1'b0;
            c_hit_reg     <= 1'b0;
            c_free_reg    <= 1'b0;
            oc_hit_reg    <= 1'b0;
            prom_reg      <= 1'b0;
            full_reg      <= 1'b0;
            ent_valid_reg <= 1'b0;
            ent_rep_reg   <= 1'b0;
            ent_val_reg   <= '0;
            ent_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.tscan && pend_reg)
            begin
                if (t_live_p && tval_q == val_reg && !t_hit_reg)
                begin
                    t_hit_reg <= 1'b1;
                    t_idx_reg <= pt;
                    t_cnt_reg <= tcnt_q;
                end
                if (t_live_p && tval_q == old_val)
                    old_t_reg <= 1'b1;
                if (!t_live_p && !t_free_reg)
                begin
                    t_free_reg     <= 1'b1;
                    t_free_idx_reg <= pt;
                end
            end
            if (cmd.cscan && pend_reg)
            begin
                if (c_live_p && cval_q == val_reg && !c_hit_reg)
                begin
                    c_hit_reg  <= 1'b1;
                    c_idx_reg  <= pc;
                    c_wt_reg   <= c_wt_p;
                    c_refs_reg <= cref_q;
                end
                if (c_live_p && cval_q == old_val && !oc_hit_reg)
                begin
                    oc_hit_reg  <= 1'b1;
                    oc_idx_reg  <= pc;
                    oc_wt_reg   <= c_wt_p;
                    oc_refs_reg <= cref_q;
                end
                if (!c_live_p && !c_free_reg)
                begin
                    c_free_reg     <= 1'b1;
                    c_free_idx_reg <= pc;
                end
            end
            if (cmd.apply && !t_hit_reg)
            begin
                prom_reg <= do_prom;
                full_reg <= prom_try && !t_free_reg;
            end
            if (cmd.rd_cap && (32'(ridx_reg) < 32'(TRACKED_ENTRIES)) && trk_live_reg[ridx_t])
            begin
                ent_valid_reg <= 1'b1;
                ent_val_reg   <= tval_q;
                ent_cnt_reg   <= tcnt_q;
                ent_rep_reg   <= tcnt_q >= rth_reg;
            end
        end
    end

    // ---------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            was_tracked    <= t_hit_reg && (op_reg == wfvf_pkg::CMD_SAMPLE);
            promoted       <= prom_reg;
            table_full     <= full_reg;
            sample_total   <= samples_reg;
            overflow_total <= aged_reg;
            entry_value    <= ent_val_reg;
            entry_count    <= ent_cnt_reg;
            entry_valid    <= ent_valid_reg;
            entry_reported <= ent_rep_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sts.in_cmd     = command;
    assign sts.scan_done  = scan_done;
    assign sts.t_hit      = t_hit_reg;
    assign sts.evict_need = evict_need;
    assign sts.out_free   = !out_valid_reg || out_ready;

    // ---------------- assertions
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) < HISTORY_DEPTH)
        else $error("history occupancy reached depth");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(prom_reg && full_reg))
        else $error("promotion both done and dropped");

    a_hit_no_prom: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && t_hit_reg) |=> !prom_reg && !full_reg)
        else $error("tracked hit raised a promotion flag");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= SMAX)
        else $error("scan counter overran");

endmodule

### rtl/windowed_frequent_value_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_frequent_value_filter: sliding-window frequent value tracker
// Counts sample weights per value, promoting frequent values to a table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: sample, clear
//   or read. Output channel (out_valid/out_ready) returns one result item per
//   command. Configuration writes go through cfg_we/cfg_index/cfg_data only
//   while the block is idle, a rule for the user that the block does not enforce;
//   they take effect at once.
//   Timing: one item at a time. A sample walks the tracked table and then the
//   candidate table one entry a cycle through their registered read ports.
//   Its result is loaded after the scans and the update step, and after an
//   eviction step when the oldest value leaves the window; the next item is
//   taken once the result is loaded. A sample of a tracked value skips the
//   candidate scan. A read passes a table read and capture first; a clear goes
//   straight to the result. The table scans set the rate.
//   Reset clears totals and all valid bits at once; no clearing pass is run,
//   and the block takes items from the first cycle after reset.
//   A finished result sits in the output register; if the receiver stalls,
//   hold the result and let the next item be accepted and worked on, which
//   then waits for the output register to free before completing.
// ----------------------------------------------------------------------------
module windowed_frequent_value_filter #(
    parameter int HISTORY_DEPTH   = wfvf_pkg::HISTORY_DEPTH_DEF,
    parameter int TRACKED_ENTRIES = wfvf_pkg::TRACKED_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [63:0] sample_value,
    input  logic [15:0]        sample_weight,
    input  logic [7:0]         read_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               was_tracked,
    output logic               promoted,
    output logic               table_full,
    output logic [31:0]        sample_total,
    output logic [31:0]        overflow_total,
    output logic signed [63:0] entry_value,
    output logic [31:0]        entry_count,
    output logic               entry_valid,
    output logic               entry_reported
);

    // control bundle down, status bundle up
    wfvf_pkg::wfvf_cmd_t cmd;
    wfvf_pkg::wfvf_sts_t sts;

    wfvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables, history window, totals and the result register
    wfvf_dp #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .TRACKED_ENTRIES (TRACKED_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .sample_value   (sample_value),
        .sample_weight  (sample_weight),
        .read_index     (read_index),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .was_tracked    (was_tracked),
        .promoted       (promoted),
        .table_full     (table_full),
        .sample_total   (sample_total),
        .overflow_total (overflow_total),
        .entry_value    (entry_value),
        .entry_count    (entry_count),
        .entry_valid    (entry_valid),
        .entry_reported (entry_reported)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the windowed frequent value filter
// Drives sample, clear and read items with random gaps on both channels,
// predicts every result from a behavioural copy of the tables kept here and
// compares each result field by field, across several register settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HDEPTH  = wfvf_pkg::HISTORY_DEPTH_DEF;
    localparam int TDEPTH  = wfvf_pkg::TRACKED_ENTRIES_DEF;
    localparam int SETTLE  = TDEPTH + HDEPTH + 40;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] value;
        logic [15:0] weight;
        logic [7:0]  index;
    } cmd_item_t;

    typedef struct packed {
        logic        was_tracked;
        logic        promoted;
        logic        table_full;
        logic [31:0] sample_total;
        logic [31:0] overflow_total;
        logic [63:0] entry_value;
        logic [31:0] entry_count;
        logic        entry_valid;
        logic        entry_reported;
    } filter_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = wfvf_pkg::REG_PROMOTE;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = wfvf_pkg::CMD_SAMPLE;
    logic signed [63:0] sample_value = '0;
    logic [15:0] sample_weight = '0;
    logic [7:0] read_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic was_tracked, promoted, table_full, entry_valid, entry_reported;
    logic [31:0] sample_total, overflow_total, entry_count;
    logic signed [63:0] entry_value;

    windowed_frequent_value_filter dut (.*);

    always #5 clk = ~clk;

    // Predictor state: a private copy of the filter's tables and registers
    logic [31:0] m_promote, m_report;
    logic [6:0]  m_window;
    logic [63:0] m_hist [HDEPTH];
    int unsigned m_fill, m_head;
    logic [63:0] m_cval [HDEPTH];
    logic [31:0] m_cwt [HDEPTH];
    int unsigned m_cref [HDEPTH];
    logic        m_clive [HDEPTH];
    logic [63:0] m_tval [TDEPTH];
    logic [31:0] m_tcnt [TDEPTH];
    logic        m_tlive [TDEPTH];
    logic [31:0] m_samples, m_aged;

    cmd_item_t      pending_items [$];
    filter_result_t expected_results [$];
    int errors = 0;
    int n_accepted = 0, n_checked = 0, n_promoted = 0, n_full = 0;
    bit stim_done = 1'b0;

    function automatic logic [31:0] sum_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int tracked_slot(logic [63:0] v);
        for (int i = 0; i < TDEPTH; i++)
            if (m_tlive[i] && m_tval[i] == v) return i;
        return -1;
    endfunction

    function automatic int candidate_slot(logic [63:0] v);
        for (int i = 0; i < HDEPTH; i++)
            if (m_clive[i] && m_cval[i] == v) return i;
        return -1;
    endfunction

    task automatic model_reset();
        m_promote = wfvf_pkg::PROMOTE_RST;
        m_window  = wfvf_pkg::WINDOW_RST;
        m_report  = wfvf_pkg::REPORT_RST;
        m_fill = 0;
        m_head = 0;
        for (int i = 0; i < HDEPTH; i++)
        begin
            m_hist[i] = '0; m_cval[i] = '0; m_cwt[i] = '0; m_cref[i] = 0; m_clive[i] = 0;
        end
        for (int i = 0; i < TDEPTH; i++)
        begin
            m_tval[i] = '0; m_tcnt[i] = '0; m_tlive[i] = 1'b0;
        end
        m_samples = '0;
        m_aged = '0;
    endtask

    // Work out the result of one accepted item and advance the copied state
    function automatic filter_result_t filter_step(cmd_item_t it);
        filter_result_t r;
        int t, c, oc, slot;
        int unsigned weff, tail;
        logic [63:0] old;
        r = '0;
        if (it.cmd == wfvf_pkg::CMD_SAMPLE)
        begin
            t = tracked_slot(it.value);
            if (t >= 0)
            begin
                m_tcnt[t] = sum_sat(m_tcnt[t], {16'd0, it.weight});
                r.was_tracked = 1'b1;
            end
            else
            begin
                tail = (m_head + m_fill) % HDEPTH;
                m_hist[tail] = it.value;
                m_fill++;
                c = candidate_slot(it.value);
                if (c < 0)
                begin
                    for (int i = 0; i < HDEPTH; i++)
                        if (!m_clive[i])
                        begin
                            m_clive[i] = 1'b1; m_cval[i] = it.value;
                            m_cwt[i] = {16'd0, it.weight}; m_cref[i] = 1;
                            break;
                        end
                end
                else
                begin
                    m_cwt[c] = sum_sat(m_cwt[c], {16'd0, it.weight});
                    m_cref[c]++;
                    if (m_cwt[c] >= m_promote)
                    begin
                        slot = -1;
                        for (int i = 0; i < TDEPTH; i++)
                            if (!m_tlive[i])
                            begin
                                slot = i;
                                break;
                            end
                        if (slot >= 0)
                        begin
                            m_tlive[slot] = 1'b1; m_tval[slot] = it.value;
                            m_tcnt[slot] = m_cwt[c];
                            r.promoted = 1'b1;
                        end
                        else
                            r.table_full = 1'b1;
                    end
                end
                weff = (m_window == 0) ? 1 : (m_window > HDEPTH ? HDEPTH : m_window);
                if (m_fill >= weff)
                begin
                    old = m_hist[m_head];
                    oc = candidate_slot(old);
                    m_head = (m_head + 1) % HDEPTH;
                    m_fill--;
                    if (oc >= 0)
                    begin
                        if (m_cref[oc] > 0) m_cref[oc]--;
                        if (m_cref[oc] == 0)
                        begin
                            if (tracked_slot(old) < 0) m_aged = sum_sat(m_aged, m_cwt[oc]);
                            m_clive[oc] = 1'b0;
                            m_cwt[oc] = '0;
                        end
                    end
                end
            end
            if (m_samples != 32'hFFFF_FFFF) m_samples++;
        end
        else if (it.cmd == wfvf_pkg::CMD_CLEAR)
        begin
            m_samples = '0;
            m_aged = '0;
            for (int i = 0; i < HDEPTH; i++) m_cwt[i] = '0;
            for (int i = 0; i < TDEPTH; i++)
            begin
                m_tcnt[i] = '0; m_tlive[i] = 1'b0; m_tval[i] = '0;
            end
        end
        else if (it.cmd == wfvf_pkg::CMD_READ)
        begin
            if (m_tlive[it.index])
            begin
                r.entry_value = m_tval[it.index];
                r.entry_count = m_tcnt[it.index];
                r.entry_valid = 1'b1;
                r.entry_reported = m_tcnt[it.index] >= m_report;
            end
        end
        r.sample_total = m_samples;
        r.overflow_total = m_aged;
        return r;
    endfunction

    // Driver: hold each item until accepted, draw a gap before the next
    int drv_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.insert(expected_results.size(),
                    filter_step(cmd_item_t'{command, sample_value, sample_weight, read_index}));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (drv_gap > 0 || pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (drv_gap > 0) drv_gap <= drv_gap - 1;
                end
                else
                begin
                    cmd_item_t it;
                    it = pending_items[0];
                    pending_items.delete(0);
                    in_valid      <= 1'b1;
                    command       <= it.cmd;
                    sample_value  <= it.value;
                    sample_weight <= it.weight;
                    read_index    <= it.index;
                    drv_gap       <= $urandom_range(0, 5);
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    int mon_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                filter_result_t e;
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation pending");
                    errors++;
                end
                else
                begin
                    e = expected_results[0];
                    expected_results.delete(0);
                    n_checked++;
                    if (e.promoted) n_promoted++;
                    if (e.table_full) n_full++;
                    if (was_tracked !== e.was_tracked)
                    begin
                        $error("was_tracked exp %0d got %0d", e.was_tracked, was_tracked);
                        errors++;
                    end
                    if (promoted !== e.promoted)
                    begin
                        $error("promoted exp %0d got %0d", e.promoted, promoted);
                        errors++;
                    end
                    if (table_full !== e.table_full)
                    begin
                        $error("table_full exp %0d got %0d", e.table_full, table_full);
                        errors++;
                    end
                    if (sample_total !== e.sample_total)
                    begin
                        $error("sample_total exp %0d got %0d", e.sample_total, sample_total);
                        errors++;
                    end
                    if (overflow_total !== e.overflow_total)
                    begin
                        $error("overflow_total exp %0d got %0d", e.overflow_total,
                               overflow_total);
                        errors++;
                    end
                    if (entry_value !== e.entry_value)
                    begin
                        $error("entry_value exp %h got %h", e.entry_value, entry_value);
                        errors++;
                    end
                    if (entry_count !== e.entry_count)
                    begin
                        $error("entry_count exp %0d got %0d", e.entry_count, entry_count);
                        errors++;
                    end
                    if (entry_valid !== e.entry_valid)
                    begin
                        $error("entry_valid exp %0d got %0d", e.entry_valid, entry_valid);
                        errors++;
                    end
                    if (entry_reported !== e.entry_reported)
                    begin
                        $error("entry_reported exp %0d got %0d", e.entry_reported,
                               entry_reported);
                        errors++;
                    end
                end
            end
            // after each taken result, stall for a random number of cycles
            if (out_valid && out_ready)
            begin
                int g;
                g = $urandom_range(0, 5);
                mon_gap   <= g;
                out_ready <= (g == 0);
            end
            else if (mon_gap > 0)
            begin
                mon_gap   <= mon_gap - 1;
                out_ready <= (mon_gap == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic add_item(logic [1:0] c, logic [63:0] v, logic [15:0] w, logic [7:0] ix);
        pending_items.insert(pending_items.size(), cmd_item_t'{c, v, w, ix});
    endtask

    // Values drawn from a small pool so that repeats, promotions and ageing occur
    function automatic logic [63:0] pick_value(int pool);
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = {$urandom, $urandom};
            1: v = 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
            2: v = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
            default: v = 64'(signed'($urandom_range(0, pool))) - 64'(pool / 2);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'd0;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    // Write a register while the block is idle
    task automatic write_reg(logic [1:0] ix, logic [31:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= ix;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (ix == wfvf_pkg::REG_PROMOTE) m_promote = d;
        else if (ix == wfvf_pkg::REG_WINDOW) m_window = d[6:0];
        else m_report = d;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(int n, int pool, int clear_pct, int read_pct);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < clear_pct)
                add_item(wfvf_pkg::CMD_CLEAR, {$urandom, $urandom}, 16'($urandom),
                         8'($urandom));
            else if (r < clear_pct + read_pct)
                add_item(wfvf_pkg::CMD_READ, {$urandom, $urandom}, 16'($urandom),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
            else if (r < clear_pct + read_pct + 2)
                add_item(CMD_UNUSED, {$urandom, $urandom}, 16'($urandom), 8'($urandom));
            else
                add_item(wfvf_pkg::CMD_SAMPLE, pick_value(pool), pick_weight(), 8'($urandom));
        end
    endtask

    initial
    begin
        model_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every command, first-weight rule, reads of empty slots
        add_item(wfvf_pkg::CMD_READ, '0, '0, 8'd0);
        add_item(wfvf_pkg::CMD_SAMPLE, 64'h8000_0000_0000_0000, 16'hFFFF, 8'hFF);
        add_item(wfvf_pkg::CMD_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, 16'd0, 8'd0);
        add_item(wfvf_pkg::CMD_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, 16'd1, 8'd0);
        add_item(wfvf_pkg::CMD_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, 16'd1, 8'd0);
        add_item(wfvf_pkg::CMD_SAMPLE, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'd0);
        add_item(wfvf_pkg::CMD_READ, '0, '0, 8'd0);
        add_item(wfvf_pkg::CMD_READ, '0, '0, 8'hFF);
        add_item(wfvf_pkg::CMD_SAMPLE, 64'h8000_0000_0000_0000, 16'd5, 8'd0);
        add_item(wfvf_pkg::CMD_SAMPLE, -64'sd1, 16'd3, 8'd0);
        add_item(wfvf_pkg::CMD_READ, '0, '0, 8'd1);
        add_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF);
        add_item(wfvf_pkg::CMD_CLEAR, '0, '0, '0);
        add_item(wfvf_pkg::CMD_READ, '0, '0, 8'd0);
        add_item(wfvf_pkg::CMD_SAMPLE, -64'sd1, 16'd1, 8'd0);
        add_item(wfvf_pkg::CMD_SAMPLE, -64'sd1, 16'd1, 8'd0);
        drain();

        // Tiny window and zero threshold: quick ageing
        write_reg(wfvf_pkg::REG_WINDOW, 32'd0);
        write_reg(wfvf_pkg::REG_PROMOTE, 32'd0);
        write_reg(wfvf_pkg::REG_REPORT, 32'hFFFF_FFFF);
        random_phase(200, 6, 2, 15);
        drain();

        write_reg(wfvf_pkg::REG_WINDOW, 32'd1);
        write_reg(wfvf_pkg::REG_PROMOTE, 32'd3);
        write_reg(wfvf_pkg::REG_REPORT, 32'd0);
        random_phase(200, 10, 2, 15);
        drain();

        // Window above depth, huge threshold: nothing promotes, table ages out
        write_reg(wfvf_pkg::REG_WINDOW, 32'd127);
        write_reg(wfvf_pkg::REG_PROMOTE, 32'hFFFF_FFFF);
        write_reg(wfvf_pkg::REG_REPORT, 32'd100);
        random_phase(250, 80, 1, 10);
        drain();

        // Lower the window below occupancy; many distinct values fill the tracked table
        write_reg(wfvf_pkg::REG_WINDOW, 32'd64);
        write_reg(wfvf_pkg::REG_PROMOTE, 32'd1);
        random_phase(100, 300, 0, 5);
        drain();
        write_reg(wfvf_pkg::REG_WINDOW, 32'd8);
        random_phase(600, 400, 0, 10);
        drain();

        write_reg(wfvf_pkg::REG_PROMOTE, 32'd20);
        write_reg(wfvf_pkg::REG_WINDOW, 32'd17);
        write_reg(wfvf_pkg::REG_REPORT, 32'd5);
        random_phase(150, 20, 3, 20);
        wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        repeat (SETTLE) @(posedge clk);
        $display("Ran %0d items and checked %0d results over several register settings,",
                 n_accepted, n_checked);
        $display("with %0d promotions and %0d dropped on a full table.", n_promoted, n_full);
        if (errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
